>>> src/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Holds screen geometry, item and result words, controller codes and
// the command/status structs; no dependencies.
package tcw_pkg;

   // Screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;

   // Internal widths derived from the geometry
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int COLX_W = COL_W + 1;
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = $clog2(CELL_COUNT);

   // Fixed field widths of the item and result words
   localparam int ACTION_W = 2;
   localparam int CHAR_W   = 8;
   localparam int RCOL_W   = 7;
   localparam int RROW_W   = 5;
   localparam int OCOL_W   = 7;
   localparam int OROW_W   = 5;
   localparam int ATTR_W   = 8;
   localparam int CELL_W   = CHAR_W + ATTR_W;
   localparam int COLOR_W  = 4;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FOREGROUND = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKGROUND = 1'd1;
   localparam logic [COLOR_W-1:0]   FG_RESET       = 4'd7;
   localparam logic [COLOR_W-1:0]   BG_RESET       = 4'd0;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [CHAR_W-1:0]   char_code;
      logic [RCOL_W-1:0]   read_col;
      logic [RROW_W-1:0]   read_row;
   } req_type;

   typedef struct packed {
      logic [OCOL_W-1:0] cursor_col;
      logic [OROW_W-1:0] cursor_row;
      logic [CHAR_W-1:0] cell_char;
      logic [ATTR_W-1:0] cell_attr;
      logic              scrolled;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_COPY,
      ST_BLANK,
      ST_CLEAR,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic take;
      logic exec;
      logic capture;
      logic sw_clear;
      logic copy;
      logic fill;
      logic fill_init;
      logic rsp_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_scroll;
      logic need_clear;
      logic need_read;
      logic copy_end;
      logic sw_last;
      logic rsp_free;
   } sts_type;

endpackage

>>> src/tcw_ctrl.sv
// Controller state machine for the text console writer.
// Sequences buffer init, item execution, scroll and clear sweeps and the
// result load; depends on tcw_pkg.
module tcw_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tcw_pkg::sts_type sts,
   output tcw_pkg::cmd_type cmd
);
   import tcw_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.fill      = 1'b1;
            cmd.fill_init = 1'b1;
            if (sts.sw_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec     = 1'b1;
            cmd.sw_clear = 1'b1;
            if (sts.need_scroll) begin
               state_in = ST_COPY;
            end else if (sts.need_clear) begin
               state_in = ST_CLEAR;
            end else if (sts.need_read) begin
               state_in = ST_READ;
            end else if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            cmd.capture = 1'b1;
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_COPY: begin
            cmd.copy = 1'b1;
            if (sts.copy_end) begin
               state_in = ST_BLANK;
            end
         end
         ST_BLANK: begin
            cmd.fill = 1'b1;
            if (sts.sw_last) begin
               state_in = ST_DONE;
            end
         end
         ST_CLEAR: begin
            cmd.fill = 1'b1;
            if (sts.sw_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // An accepted word is executed in the very next cycle
   a_take_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> state_ff == ST_EXEC)
      else $error("accepted word not executed next cycle");

   // Bottom row blanking only follows the row copy
   a_blank_after_copy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BLANK && $past(state_ff) != ST_BLANK) |-> $past(state_ff) == ST_COPY)
      else $error("blank sweep entered without copy");

   // Init sweep runs only straight out of reset
   a_init_from_reset: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT && !$past(reset)) |-> $past(state_ff) == ST_INIT)
      else $error("init sweep re-entered");

endmodule

>>> src/tcw_dpath.sv
// Datapath for the text console writer: screen buffer memory, cursor,
// sweep counter, request latch and result register; depends on tcw_pkg.
module tcw_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  tcw_pkg::cmd_type                cmd,
   output tcw_pkg::sts_type                sts,
   input  tcw_pkg::req_type                req_payload,
   input  logic [tcw_pkg::ATTR_W-1:0]      attr,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tcw_pkg::rsp_type                rsp_payload
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] mem [CELL_COUNT];
   logic [CELL_W-1:0] mem_rd_ff;

   req_type           req_ff;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] sw_ff, sw_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic              scroll_ff, scroll_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;

   logic [COLX_W-1:0] col_inc, col_tab;
   logic              is_put, is_lf, is_cr, is_tab, is_char;
   logic              wrap, last_row, rd_ok, copy_end, sw_last;
   logic [ADDR_W-1:0] cur_addr, req_addr;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [CELL_W-1:0] wr_data;

   // Decode the latched word against the cursor
   always_comb begin
      is_lf   = 1'b0;
      is_cr   = 1'b0;
      is_tab  = 1'b0;
      is_char = 1'b0;
      case (req_ff.char_code)
         CH_LF:   is_lf   = 1'b1;
         CH_CR:   is_cr   = 1'b1;
         CH_TAB:  is_tab  = 1'b1;
         default: is_char = 1'b1;
      endcase
      is_put   = req_ff.action == ACT_PUT;
      col_inc  = {1'b0, col_ff} + COLX_W'(1);
      col_tab  = ({1'b0, col_ff} + COLX_W'(8)) & ~COLX_W'(7);
      wrap     = is_lf || (is_tab && col_tab >= COLUMNS) || (is_char && col_inc >= COLUMNS);
      last_row = row_ff == ROW_W'(ROWS - 1);
      rd_ok    = (req_ff.read_col < COLUMNS) && (req_ff.read_row < ROWS);
      cur_addr = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);
      req_addr = ADDR_W'(req_ff.read_row) * ADDR_W'(COLUMNS) + ADDR_W'(req_ff.read_col);
      copy_end = sw_ff == ADDR_W'(CELL_COUNT - COLUMNS);
      sw_last  = sw_ff == ADDR_W'(CELL_COUNT - 1);
   end

   // Next cursor, scroll flag and read cell
   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      scroll_in = scroll_ff;
      cell_in   = cell_ff;
      if (cmd.exec) begin
         scroll_in = is_put && wrap && last_row;
         cell_in   = '0;
         case (req_ff.action)
            ACT_PUT: begin
               if (wrap) begin
                  col_in = '0;
                  if (!last_row) begin
                     row_in = row_ff + ROW_W'(1);
                  end
               end else if (is_cr) begin
                  col_in = '0;
               end else if (is_tab) begin
                  col_in = col_tab[COL_W-1:0];
               end else begin
                  col_in = col_inc[COL_W-1:0];
               end
            end
            ACT_CLEAR: begin
               col_in = '0;
               row_in = '0;
            end
            default: begin
               col_in = col_ff;
            end
         endcase
      end else if (cmd.capture) begin
         cell_in = mem_rd_ff;
      end
   end

   // Buffer port selection: character write, cell read, row copy or blank fill
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cur_addr;
      wr_data = {attr, req_ff.char_code};
      rd_en   = 1'b0;
      rd_addr = req_addr;
      if (cmd.exec) begin
         wr_en = is_put && is_char;
         rd_en = (req_ff.action == ACT_READ) && rd_ok;
      end else if (cmd.copy) begin
         wr_en   = sw_ff != '0;
         wr_addr = sw_ff - ADDR_W'(1);
         wr_data = mem_rd_ff;
         rd_en   = !copy_end;
         rd_addr = sw_ff + ADDR_W'(COLUMNS);
      end else if (cmd.fill) begin
         wr_en   = 1'b1;
         wr_addr = sw_ff;
         wr_data = {(cmd.fill_init ? RESET_ATTR : attr), CH_BLANK};
      end
   end

   // Advance the sweep counter
   always_comb begin
      sw_in = sw_ff;
      if (cmd.sw_clear) begin
         sw_in = '0;
      end else if (cmd.copy && !copy_end) begin
         sw_in = sw_ff + ADDR_W'(1);
      end else if (cmd.fill && !sw_last) begin
         sw_in = sw_ff + ADDR_W'(1);
      end
   end

   // Screen buffer
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_rd_ff <= mem[rd_addr];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         sw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         sw_ff  <= sw_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_comb begin
      rsp_in.cursor_col = OCOL_W'(col_in);
      rsp_in.cursor_row = OROW_W'(row_in);
      rsp_in.cell_char  = cell_in[CHAR_W-1:0];
      rsp_in.cell_attr  = cell_in[CELL_W-1:CHAR_W];
      rsp_in.scrolled   = scroll_in;
   end

   always_ff @(posedge clock) begin
      scroll_ff <= scroll_in;
      cell_ff   <= cell_in;
      if (cmd.take) begin
         req_ff <= req_payload;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign sts.need_scroll = is_put && wrap && last_row;
   assign sts.need_clear  = req_ff.action == ACT_CLEAR;
   assign sts.need_read   = (req_ff.action == ACT_READ) && rd_ok;
   assign sts.copy_end    = copy_end;
   assign sts.sw_last     = sw_last;
   assign sts.rsp_free    = !rsp_valid_ff || rsp_ready;

   // Cursor never leaves the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff < COLUMNS) && (row_ff < ROWS))
      else $error("cursor out of screen");

   // Buffer writes stay inside the buffer
   a_write_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> wr_addr < CELL_COUNT)
      else $error("buffer write out of range");

   // A scroll leaves the cursor at column 0 of the last row
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && sts.need_scroll) |=> (row_ff == ROW_W'(ROWS - 1)) && (col_ff == '0))
      else $error("scroll left cursor off the last row");

endmodule

>>> src/text_console_writer_top.sv
// Top level of the text console writer: color registers, controller and
// datapath. Depends on tcw_pkg, tcw_ctrl and tcw_dpath.
//
// Character-cell console with a COLUMNS x ROWS buffer (80 x 25) of
// attribute/character cells and a cursor; every word taken on req_ returns
// one word on rsp_. After reset the block sweeps the buffer to blanks with
// attribute 0x07, one cell per cycle, and takes no word until the sweep
// ends; color writes on csr_ are taken throughout.
// Work per word is set by the single buffer memory (one write and one
// registered read per cycle): a put of a character, return, newline or tab
// that does not scroll and a read need no sweep, while a clear and a put
// that scrolls walk the whole buffer one cell per cycle, the scroll as a row
// copy and then a blank of the bottom row. A finished result waits in an
// output register, so the next word is accepted while it is still waiting
// to be taken.
module text_console_writer_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  tcw_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tcw_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_wr_en,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0]       csr_wdata
);
   import tcw_pkg::*;

   logic [COLOR_W-1:0] fg_ff;
   logic [COLOR_W-1:0] bg_ff;
   logic [ATTR_W-1:0]  attr;
   cmd_type            cmd;
   sts_type            sts;

   // Color registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= FG_RESET;
         bg_ff <= BG_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FOREGROUND: fg_ff <= csr_wdata;
            CSR_BACKGROUND: bg_ff <= csr_wdata;
            default: begin
               fg_ff <= fg_ff;
            end
         endcase
      end
   end

   assign attr = {bg_ff, fg_ff};

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tcw_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .attr        (attr),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for text_console_writer_top: drives put, clear, read and unused-action words,
// predicts every status word from a copy of the screen and cursor, and checks it.
// Depends on tcw_pkg and the RTL under src/.
module tb;
   import tcw_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int TAB_STOP    = 8;
   localparam int GAP_PERCENT = 30;
   localparam int PHASE_WORDS = 215;
   localparam int PHASES      = 6;
   localparam int SETTLE      = CELL_COUNT + 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_FOREGROUND;
   logic [COLOR_W-1:0] csr_wdata = '0;

   // Words waiting to be driven and status words still due from the block
   req_type words_to_send[$];
   rsp_type status_due[$];
   int mismatches = 0;
   bit quiet = 1'b0;

   // Shadow screen, cursor and colors
   logic [CELL_W-1:0] screen [CELL_COUNT];
   int unsigned cur_c;
   int unsigned cur_r;
   logic [COLOR_W-1:0] fg_now;
   logic [COLOR_W-1:0] bg_now;

   text_console_writer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic [ATTR_W-1:0] attr_now();
      return {bg_now, fg_now};
   endfunction

   // Move to column 0 of the next row; scroll up when past the last row
   function automatic bit line_feed();
      int i;
      cur_c = 0;
      cur_r++;
      if (cur_r < ROWS) return 1'b0;
      for (i = 0; i < CELL_COUNT - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen[i] = {attr_now(), CH_BLANK};
      cur_r = ROWS - 1;
      return 1'b1;
   endfunction

   // Apply one word to the shadow console and return the status it reports
   function automatic rsp_type console_apply(req_type w);
      rsp_type r;
      logic [CELL_W-1:0] cell_word;
      int i;
      r = '0;
      case (w.action)
         ACT_PUT: begin
            if (w.char_code == CH_LF) begin
               r.scrolled = line_feed();
            end else if (w.char_code == CH_CR) begin
               cur_c = 0;
            end else if (w.char_code == CH_TAB) begin
               cur_c = (cur_c + TAB_STOP) & ~(TAB_STOP - 1);
               if (cur_c >= COLUMNS) r.scrolled = line_feed();
            end else begin
               screen[cur_r * COLUMNS + cur_c] = {attr_now(), w.char_code};
               cur_c++;
               if (cur_c >= COLUMNS) r.scrolled = line_feed();
            end
         end
         ACT_CLEAR: begin
            for (i = 0; i < CELL_COUNT; i++) screen[i] = {attr_now(), CH_BLANK};
            cur_c = 0;
            cur_r = 0;
         end
         ACT_READ: begin
            if (w.read_col < COLUMNS && w.read_row < ROWS) begin
               cell_word = screen[w.read_row * COLUMNS + w.read_col];
               r.cell_char = cell_word[CHAR_W-1:0];
               r.cell_attr = cell_word[CELL_W-1:CHAR_W];
            end
         end
         default: ;
      endcase
      r.cursor_col = cur_c[OCOL_W-1:0];
      r.cursor_row = cur_r[OROW_W-1:0];
      return r;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // Driver: predict on accept, then hold, advance or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) status_due.push_back(console_apply(req_payload));
         if (!req_valid || req_ready) begin
            if (words_to_send.size() != 0 &&
                (quiet || $urandom_range(0, 99) >= GAP_PERCENT)) begin
               req_payload <= words_to_send.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each taken status word with the oldest one due
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (status_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected word, expected none, actual %h", $time, rsp_payload);
            end else begin
               want = status_due.pop_front();
               check_field("cursor_col", want.cursor_col, rsp_payload.cursor_col);
               check_field("cursor_row", want.cursor_row, rsp_payload.cursor_row);
               check_field("cell_char", want.cell_char, rsp_payload.cell_char);
               check_field("cell_attr", want.cell_attr, rsp_payload.cell_attr);
               check_field("scrolled", want.scrolled, rsp_payload.scrolled);
            end
         end
         rsp_ready <= quiet || ($urandom_range(0, 99) >= GAP_PERCENT);
      end
   end

   function automatic void queue_word(logic [ACTION_W-1:0] act, logic [CHAR_W-1:0] ch,
                                      logic [RCOL_W-1:0] col, logic [RROW_W-1:0] row);
      req_type w;
      w.action = act;
      w.char_code = ch;
      w.read_col = col;
      w.read_row = row;
      words_to_send.push_back(w);
   endfunction

   // Unused fields get random content so every bit toggles
   function automatic void put_char(logic [CHAR_W-1:0] ch);
      queue_word(ACT_PUT, ch, RCOL_W'($urandom_range(0, 127)), RROW_W'($urandom_range(0, 31)));
   endfunction

   function automatic void read_cell(int col, int row);
      queue_word(ACT_READ, CHAR_W'($urandom_range(0, 255)), RCOL_W'(col), RROW_W'(row));
   endfunction

   // Add one short sequence: text, line breaks, tabs, reads, clear or noise
   function automatic void add_sequence();
      int kind;
      int n;
      int i;
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(COLUMNS, COLUMNS + 20)
                                         : $urandom_range(1, 40);
         for (i = 0; i < n; i++) put_char(CHAR_W'($urandom_range(0, 255)));
      end else if (kind < 55) begin
         n = $urandom_range(1, 4);
         for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) == 1) put_char(CH_CR);
            put_char(CH_LF);
         end
      end else if (kind < 65) begin
         n = $urandom_range(1, 12);
         for (i = 0; i < n; i++) put_char(CH_TAB);
      end else if (kind < 88) begin
         n = $urandom_range(1, 6);
         for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0)
               read_cell($urandom_range(0, 127), $urandom_range(0, 31));
            else if ($urandom_range(0, 2) == 0)
               read_cell($urandom_range(0, COLUMNS - 1), ROWS - 1);
            else
               read_cell($urandom_range(0, COLUMNS - 1), $urandom_range(0, ROWS - 1));
         end
      end else if (kind < 93) begin
         queue_word(ACT_UNUSED, CHAR_W'($urandom_range(0, 255)),
                    RCOL_W'($urandom_range(0, 127)), RROW_W'($urandom_range(0, 31)));
      end else if (kind < 95) begin
         queue_word(ACT_CLEAR, CHAR_W'($urandom_range(0, 255)),
                    RCOL_W'($urandom_range(0, 127)), RROW_W'($urandom_range(0, 31)));
      end else begin
         queue_word(ACTION_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                    RCOL_W'($urandom_range(0, 127)), RROW_W'($urandom_range(0, 31)));
      end
   endfunction

   // Wait until every word is sent and every status word is back
   task automatic drain();
      while (words_to_send.size() != 0 || req_valid || status_due.size() != 0)
         @(negedge clock);
   endtask

   // Write both color registers while the block is idle
   task automatic set_colors(logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_FOREGROUND;
      csr_wdata <= fg;
      @(posedge clock);
      csr_index <= CSR_BACKGROUND;
      csr_wdata <= bg;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      fg_now = fg;
      bg_now = bg;
   endtask

   // Stimulus and end of run
   initial begin
      int i;
      int p;
      for (i = 0; i < CELL_COUNT; i++) screen[i] = {RESET_ATTR, CH_BLANK};
      cur_c = 0;
      cur_r = 0;
      fg_now = FG_RESET;
      bg_now = BG_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset colors, corners, out-of-range reads, odd bytes, unused action
      read_cell(0, 0);
      read_cell(COLUMNS - 1, ROWS - 1);
      read_cell(127, 0);
      read_cell(0, 31);
      put_char(8'h41);
      put_char(8'h00);
      put_char(8'hFF);
      read_cell(0, 0);
      queue_word(ACT_UNUSED, 8'hFF, 7'h7F, 5'h1F);
      put_char(CH_CR);
      drain();
      set_colors(4'hF, 4'hF);
      // Directed: new attribute, tab wrap at the line end, clear
      put_char(8'h7F);
      read_cell(0, 0);
      for (i = 0; i < COLUMNS / TAB_STOP; i++) put_char(CH_TAB);
      put_char(CH_LF);
      queue_word(ACT_CLEAR, 8'h00, 7'h00, 5'h00);
      read_cell(5, 5);

      // Random phases, each with its own colors; one phase with no gaps
      for (p = 0; p < PHASES; p++) begin
         drain();
         case (p)
            0: set_colors(4'h0, 4'h0);
            1: set_colors(4'hF, 4'h0);
            2: set_colors(4'h0, 4'hF);
            default: set_colors(COLOR_W'($urandom_range(0, 15)),
                                COLOR_W'($urandom_range(0, 15)));
         endcase
         quiet = (p == 3);
         while (words_to_send.size() < PHASE_WORDS) add_sequence();
      end
      drain();
      quiet = 1'b0;
      repeat (SETTLE) @(posedge clock);

      if (mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #200_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
